@@ hw/rtl/ppi_pkg.sv @@
// Shared types and constants for the 8255-style parallel port block.
// No dependencies; imported by every module of the block.
package ppi_pkg;

  typedef enum logic {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } ppi_cmd_t;

  typedef enum logic [1:0] {
    SEL_PORT_A = 2'd0,
    SEL_PORT_B = 2'd1,
    SEL_PORT_C = 2'd2,
    SEL_CTRL   = 2'd3
  } ppi_sel_t;

  localparam logic [1:0] MODE_0 = 2'd0;
  localparam logic [1:0] MODE_1 = 2'd1;
  localparam logic [1:0] MODE_2 = 2'd2;

  // dir_flags bit positions (set: input)
  localparam int DIR_C_LOW  = 0;
  localparam int DIR_B      = 1;
  localparam int DIR_C_HIGH = 2;
  localparam int DIR_A      = 3;

  localparam logic [5:0] STATUS_FILL = 6'h1F; // 0x3E in bits 6..1

  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 24;

  typedef struct packed {
    ppi_cmd_t   cmd;
    ppi_sel_t   port_sel;
    logic [7:0] wdata;
    logic [7:0] psg_rdata;
    logic       tape_level;
    logic       vsync;
  } ppi_req_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       psg_write;
    logic [7:0] psg_wdata;
    logic [3:0] key_row;
    logic       psg_bdir;
    logic       psg_bc1;
    logic       tape_motor;
  } ppi_res_t;

endpackage

@@ hw/rtl/ppi_8255_port_block_core.sv @@
// Top level of the 8255-style parallel port block: input register,
// access decode with port state, result register. Depends on ppi_pkg,
// ppi_access and ppi_out_stage.
// Each access passes the input register and then the result register
// before m_tvalid rises; the result register decouples the sides.
// Throughput: one access per cycle while m_tready is high.
// Reset (rst, synchronous, active high): all ports output, mode 0, latches,
// handshake images and side outputs cleared, both pipeline stages empty.
module ppi_8255_port_block_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // wdata[7:0], psg_rdata[15:8], tape_level[16], vsync[17], zero fill
  input  logic [ppi_pkg::IN_TDATA_W-1:0]      s_tdata,
  // cmd[0], port_sel[2:1]
  input  logic [ppi_pkg::IN_TUSER_W-1:0]      s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // rdata[7:0], psg_write[8], psg_wdata[16:9], key_row[20:17],
  // psg_bdir[21], psg_bc1[22], tape_motor[23]
  output logic [ppi_pkg::OUT_TDATA_W-1:0]     m_tdata
);
  import ppi_pkg::*;

  ppi_req_t req_q;
  ppi_res_t res;
  logic     req_valid;
  logic     out_ready;
  logic     fire;

  assign fire     = req_valid && out_ready;
  assign s_tready = !req_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (s_tready) begin
      req_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req_q.cmd        <= ppi_cmd_t'(s_tuser[0]);
      req_q.port_sel   <= ppi_sel_t'(s_tuser[2:1]);
      req_q.wdata      <= s_tdata[7:0];
      req_q.psg_rdata  <= s_tdata[15:8];
      req_q.tape_level <= s_tdata[16];
      req_q.vsync      <= s_tdata[17];
    end
  end

  ppi_access u_access (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .req  (req_q),
    .res  (res)
  );

  ppi_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req_valid),
    .in_ready (out_ready),
    .in_res   (res),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

@@ hw/rtl/ppi_access.sv @@
// Port state registers and combinational access decode.
// Depends on ppi_pkg.
module ppi_access (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  ppi_pkg::ppi_req_t req,
  output ppi_pkg::ppi_res_t res
);
  import ppi_pkg::*;

  logic [1:0] mode_a, mode_a_next;
  logic       mode_b, mode_b_next;
  logic [3:0] dir_flags, dir_flags_next;
  logic [3:0] latch_c_low, latch_c_low_next;
  logic [3:0] latch_c_high, latch_c_high_next;
  logic [7:0] handshake_a, handshake_a_next;
  logic [2:0] handshake_b, handshake_b_next;
  logic [3:0] row_reg, row_reg_next;
  logic [1:0] psg_func, psg_func_next;
  logic       motor_reg, motor_reg_next;

  logic       low_apply;
  logic       high_apply;
  logic [7:0] port_c_rd;
  logic [7:0] rd;
  logic       pw;
  logic [7:0] pwd;

  // port C read image
  always_comb begin
    port_c_rd = 8'h00;
    if (!dir_flags[DIR_C_LOW]) begin
      port_c_rd[3:0] = mode_b ? {1'b0, handshake_b} : latch_c_low;
      if (mode_a != MODE_0) port_c_rd[3] = handshake_a[3];
    end
    if (!dir_flags[DIR_C_HIGH]) begin
      port_c_rd[7:4] = (mode_a == MODE_0) ? latch_c_high : handshake_a[7:4];
    end
  end

  always_comb begin
    mode_a_next       = mode_a;
    mode_b_next       = mode_b;
    dir_flags_next    = dir_flags;
    latch_c_low_next  = latch_c_low;
    latch_c_high_next = latch_c_high;
    handshake_a_next  = handshake_a;
    handshake_b_next  = handshake_b;
    row_reg_next      = row_reg;
    psg_func_next     = psg_func;
    motor_reg_next    = motor_reg;
    low_apply         = 1'b0;
    high_apply        = 1'b0;
    rd                = 8'h00;
    pw                = 1'b0;
    pwd               = 8'h00;

    if (req.cmd == CMD_READ) begin
      unique case (req.port_sel)
        SEL_PORT_A: begin
          if (dir_flags[DIR_A] || mode_a == MODE_2) rd = req.psg_rdata;
        end
        SEL_PORT_B: begin
          if (dir_flags[DIR_B]) rd = {req.tape_level, STATUS_FILL, req.vsync};
        end
        SEL_PORT_C: rd = port_c_rd;
        SEL_CTRL:   rd = 8'h00;
        default:    rd = 8'h00;
      endcase
    end else begin
      unique case (req.port_sel)
        SEL_PORT_A: begin
          if (!dir_flags[DIR_A] || mode_a == MODE_2) begin
            pw  = 1'b1;
            pwd = req.wdata;
          end
        end
        SEL_PORT_B: ;
        SEL_PORT_C: begin
          if (!dir_flags[DIR_C_LOW]) begin
            latch_c_low_next = req.wdata[3:0];
            low_apply        = 1'b1;
          end
          if (!dir_flags[DIR_C_HIGH]) begin
            latch_c_high_next = req.wdata[7:4];
            high_apply        = 1'b1;
          end
        end
        SEL_CTRL: begin
          if (req.wdata[7]) begin
            // mode word
            mode_a_next       = req.wdata[6] ? MODE_2 : {1'b0, req.wdata[5]};
            mode_b_next       = req.wdata[2];
            dir_flags_next    = {req.wdata[4], req.wdata[3], req.wdata[1], req.wdata[0]};
            latch_c_low_next  = 4'h0;
            latch_c_high_next = 4'h0;
            handshake_a_next  = 8'h00;
            handshake_b_next  = 3'h0;
            row_reg_next      = 4'h0;
            psg_func_next     = 2'h0;
            motor_reg_next    = 1'b0;
            pw                = 1'b1;
            pwd               = 8'h00;
          end else if (!req.wdata[3]) begin
            latch_c_low_next[req.wdata[2:1]] = req.wdata[0];
            low_apply = 1'b1;
          end else begin
            latch_c_high_next[req.wdata[2:1]] = req.wdata[0];
            high_apply = 1'b1;
          end
        end
        default: ;
      endcase
    end

    if (low_apply) begin
      if (mode_a != MODE_0) handshake_a_next[3] = latch_c_low_next[3];
      if (!mode_b) row_reg_next = latch_c_low_next;
      else handshake_b_next = latch_c_low_next[2:0];
    end
    if (high_apply) begin
      if (mode_a == MODE_0) begin
        psg_func_next  = latch_c_high_next[3:2];
        motor_reg_next = latch_c_high_next[0];
      end else begin
        handshake_a_next[7:4] = handshake_a_next[7:4] | latch_c_high_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_a       <= MODE_0;
      mode_b       <= 1'b0;
      dir_flags    <= 4'h0;
      latch_c_low  <= 4'h0;
      latch_c_high <= 4'h0;
      handshake_a  <= 8'h00;
      handshake_b  <= 3'h0;
      row_reg      <= 4'h0;
      psg_func     <= 2'h0;
      motor_reg    <= 1'b0;
    end else if (fire) begin
      mode_a       <= mode_a_next;
      mode_b       <= mode_b_next;
      dir_flags    <= dir_flags_next;
      latch_c_low  <= latch_c_low_next;
      latch_c_high <= latch_c_high_next;
      handshake_a  <= handshake_a_next;
      handshake_b  <= handshake_b_next;
      row_reg      <= row_reg_next;
      psg_func     <= psg_func_next;
      motor_reg    <= motor_reg_next;
    end
  end

  always_comb begin
    res.rdata      = rd;
    res.psg_write  = pw;
    res.psg_wdata  = pwd;
    res.key_row    = row_reg_next;
    res.psg_bdir   = psg_func_next[1];
    res.psg_bc1    = psg_func_next[0];
    res.tape_motor = motor_reg_next;
  end

`ifndef SYNTHESIS
  a_mode_word_clears: assert property (@(posedge clk) disable iff (rst)
    fire && req.cmd == CMD_WRITE && req.port_sel == SEL_CTRL && req.wdata[7]
    |=> row_reg == 4'h0 && psg_func == 2'h0 && !motor_reg && handshake_a == 8'h00)
    else $error("mode word did not clear port C state");

  a_read_no_side_effect: assert property (@(posedge clk) disable iff (rst)
    fire && req.cmd == CMD_READ
    |=> $stable(latch_c_low) && $stable(latch_c_high) && $stable(handshake_a)
        && $stable(row_reg) && $stable(dir_flags))
    else $error("read access changed port state");

  a_mode_a_legal: assert property (@(posedge clk) disable iff (rst)
    mode_a != 2'd3)
    else $error("port A mode out of range");

  a_input_half_holds: assert property (@(posedge clk) disable iff (rst)
    fire && req.cmd == CMD_WRITE && req.port_sel == SEL_PORT_C && dir_flags[DIR_C_LOW]
    |=> $stable(latch_c_low))
    else $error("input port C low half took a write");

  a_psg_write_on_write: assert property (@(posedge clk) disable iff (rst)
    fire && res.psg_write |-> req.cmd == CMD_WRITE
      && (req.port_sel == SEL_PORT_A || req.port_sel == SEL_CTRL))
    else $error("sound chip transfer from wrong access");
`endif

endmodule

@@ hw/rtl/ppi_out_stage.sv @@
// Result register with stream handshake toward the master side.
// Depends on ppi_pkg.
module ppi_out_stage (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  ppi_pkg::ppi_res_t                   in_res,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [ppi_pkg::OUT_TDATA_W-1:0]     m_tdata
);
  import ppi_pkg::*;

  ppi_res_t res_q;
  logic     valid_q;

  assign in_ready = !valid_q || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (in_ready) begin
      valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) res_q <= in_res;
  end

  assign m_tvalid = valid_q;
  assign m_tdata  = {res_q.tape_motor, res_q.psg_bc1, res_q.psg_bdir, res_q.key_row,
                     res_q.psg_wdata, res_q.psg_write, res_q.rdata};

endmodule
